>>> design/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants of the points-in-triangle counter
// Transaction structs, queue entry, operation codes and back-end states.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int COORD_BITS   = 24;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int DIFF_W       = COORD_BITS + 1;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int ACC_W        = PROD_W + 2;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QFILL_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic                          req_type;
		logic [IDX_W-1:0]              vertex_index;
		logic signed [COORD_BITS-1:0]  coord_x;
		logic signed [COORD_BITS-1:0]  coord_y;
		logic [IDX_W-1:0]              corner_a;
		logic [IDX_W-1:0]              corner_b;
		logic [IDX_W-1:0]              corner_c;
	} req_t;

	typedef struct packed {
		logic [CNT_W-1:0] inside_count;
		logic             bad_index;
	} rsp_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct packed {
		op_t                           op;
		logic                          bad;
		logic [IDX_W-1:0]              vertex_index;
		logic signed [COORD_BITS-1:0]  coord_x;
		logic signed [COORD_BITS-1:0]  coord_y;
		logic [IDX_W-1:0]              corner_a;
		logic [IDX_W-1:0]              corner_b;
		logic [IDX_W-1:0]              corner_c;
	} entry_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_RD_B,
		BK_RD_C,
		BK_CAP_C,
		BK_AREA_MUL,
		BK_AREA,
		BK_ABS,
		BK_SCAN,
		BK_DRAIN,
		BK_RESULT
	} bk_state_t;

endpackage

`default_nettype wire

>>> design/points_in_triangle_count.sv
// ----------------------------------------------------------------------------
// points_in_triangle_count: top level of the points-in-triangle counter
// Counts loaded vertices lying strictly inside a queried triangle.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready, req): req_type 0 loads one vertex into
//   slot vertex_index; req_type 1 queries the triangle of corner slots
//   corner_a/b/c. Loads give no response; each query gives one transaction
//   on the rsp channel (rsp_valid/rsp_ready, rsp).
//   cfg channel (cfg_valid/cfg_ready, cfg_data) writes vertex_count and is always
//   ready; the user writes it only while the block is idle, unchecked by the block.
//   A two-entry queue sits between intake and the scan engine, so requests
//   keep flowing in while the engine is busy or a response waits.
//   A load is written straight from the queue. A bad-corner query goes
//   straight to the result; a valid one reads its corners, forms the area and
//   scans n vertices (n the effective vertex_count), one vertex per cycle, from the
//   single-port vertex store. Degenerate triangles skip the scan.
//   Reset (arst_n low) clears vertex_count, the queue and the engine; the
//   vertex store is not cleared, so only written slots may be queried.
//   A stalled receiver holds the response; loads still proceed, a further
//   query waits at its end until the response register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module points_in_triangle_count (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_ready,
	input  wire ptc_pkg::req_t               req,
	output logic                             rsp_valid,
	input  wire logic                        rsp_ready,
	output ptc_pkg::rsp_t                    rsp,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [ptc_pkg::CNT_W-1:0]   cfg_data
);

	logic [ptc_pkg::CNT_W-1:0] vcount_q;
	logic [ptc_pkg::CNT_W-1:0] n_eff;
	logic                      q_valid;
	ptc_pkg::entry_t           q_entry;
	logic                      q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
		end else if (cfg_valid) begin
			vcount_q <= cfg_data;
		end
	end

	// counts above the store depth act as the full store
	assign n_eff = (vcount_q > ptc_pkg::CNT_W'(ptc_pkg::MAX_VERTICES)) ?
	               ptc_pkg::CNT_W'(ptc_pkg::MAX_VERTICES) : vcount_q;

	ptc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.n_eff     (n_eff),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop)
	);

	ptc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.n_eff     (n_eff),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

>>> design/ptc_front.sv
// ----------------------------------------------------------------------------
// ptc_front: request intake and classification
// Accepts request transactions, tags them as load or query, checks the
// corner slots against the vertex count and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_ready,
	input  wire ptc_pkg::req_t               req,
	input  wire logic [ptc_pkg::CNT_W-1:0]   n_eff,
	output logic                             q_valid,
	output ptc_pkg::entry_t                  q_entry,
	input  wire logic                        q_pop
);

	ptc_pkg::entry_t                 slot_q [ptc_pkg::QUEUE_DEPTH];
	logic [ptc_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [ptc_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [ptc_pkg::QFILL_W-1:0]     fill_q;
	ptc_pkg::entry_t                 cls;
	logic                            push;
	logic                            pop;

	// classification: corner out of range flags the query at intake
	always_comb begin
		cls.op           = req.req_type ? ptc_pkg::OP_QUERY : ptc_pkg::OP_LOAD;
		cls.vertex_index = req.vertex_index;
		cls.coord_x      = req.coord_x;
		cls.coord_y      = req.coord_y;
		cls.corner_a     = req.corner_a;
		cls.corner_b     = req.corner_b;
		cls.corner_c     = req.corner_c;
		cls.bad          = req.req_type &&
		                   ((ptc_pkg::CNT_W'(req.corner_a) >= n_eff) ||
		                    (ptc_pkg::CNT_W'(req.corner_b) >= n_eff) ||
		                    (ptc_pkg::CNT_W'(req.corner_c) >= n_eff));
	end

	assign req_ready = (fill_q != ptc_pkg::QFILL_W'(ptc_pkg::QUEUE_DEPTH));
	assign q_valid   = (fill_q != '0);
	assign q_entry   = slot_q[rd_ptr_q];
	assign push      = req_valid && req_ready;
	assign pop       = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == ptc_pkg::QPTR_W'(ptc_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == ptc_pkg::QPTR_W'(ptc_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/ptc_back.sv
// ----------------------------------------------------------------------------
// ptc_back: vertex store and triangle scan engine
// Executes queued loads and queries. A query reads its corners, forms the
// doubled area, then streams every participating vertex through a
// five-stage barycentric test and counts the hits.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [ptc_pkg::CNT_W-1:0]   n_eff,
	input  wire logic                        q_valid,
	input  wire ptc_pkg::entry_t             q_entry,
	output logic                             q_pop,
	output logic                             rsp_valid,
	input  wire logic                        rsp_ready,
	output ptc_pkg::rsp_t                    rsp
);

	localparam int CW = ptc_pkg::COORD_BITS;
	localparam int DW = ptc_pkg::DIFF_W;
	localparam int PW = ptc_pkg::PROD_W;
	localparam int AW = ptc_pkg::ACC_W;

	ptc_pkg::bk_state_t           state_q, state_d;

	// vertex store, {x, y}
	logic [2*CW-1:0]              mem [ptc_pkg::MAX_VERTICES];
	logic [2*CW-1:0]              rdata_q;
	logic                         mem_we;
	logic                         rd_en;
	logic [ptc_pkg::IDX_W-1:0]    rd_addr;
	logic signed [CW-1:0]         rd_x, rd_y;

	ptc_pkg::entry_t              cur_q;
	logic                         bad_q;
	logic signed [CW-1:0]         pa_x_q, pa_y_q, pb_x_q, pb_y_q;
	logic signed [DW-1:0]         e1x_q, e1y_q, e2x_q, e2y_q;
	logic signed [PW-1:0]         am1_q, am2_q;
	logic signed [AW-1:0]         area_q;
	logic                         flip_q;
	logic [ptc_pkg::CNT_W-1:0]    j_q;
	logic [ptc_pkg::CNT_W-1:0]    count_q;
	logic                         scan_issue;
	logic                         corner_hit;

	// scan pipeline
	logic                         v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [DW-1:0]         dx_s2, dy_s2;
	logic signed [PW-1:0]         p_e2y_dx_s3, p_e2x_dy_s3, p_e1x_dy_s3, p_e1y_dx_s3;
	logic signed [AW-1:0]         s_s4, t_s4;
	logic                         s_pos_s5, t_pos_s5;
	logic signed [AW-1:0]         sum_s5;
	logic                         hit;

	logic                         rsp_valid_q;
	ptc_pkg::rsp_t                rsp_q;

	assign rd_x = rdata_q[2*CW-1:CW];
	assign rd_y = rdata_q[CW-1:0];

	assign corner_hit = (j_q[ptc_pkg::IDX_W-1:0] == cur_q.corner_a) ||
	                    (j_q[ptc_pkg::IDX_W-1:0] == cur_q.corner_b) ||
	                    (j_q[ptc_pkg::IDX_W-1:0] == cur_q.corner_c);

	assign hit = v_s5 && s_pos_s5 && t_pos_s5 && (sum_s5 < area_q);

	// sequencer
	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		mem_we     = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = '0;
		scan_issue = 1'b0;
		unique case (state_q)
			ptc_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_entry.op == ptc_pkg::OP_LOAD) begin
						mem_we = 1'b1;
					end else if (q_entry.bad) begin
						state_d = ptc_pkg::BK_RESULT;
					end else begin
						rd_en   = 1'b1;
						rd_addr = q_entry.corner_a;
						state_d = ptc_pkg::BK_RD_B;
					end
				end
			end
			ptc_pkg::BK_RD_B: begin
				rd_en   = 1'b1;
				rd_addr = cur_q.corner_b;
				state_d = ptc_pkg::BK_RD_C;
			end
			ptc_pkg::BK_RD_C: begin
				rd_en   = 1'b1;
				rd_addr = cur_q.corner_c;
				state_d = ptc_pkg::BK_CAP_C;
			end
			ptc_pkg::BK_CAP_C:    state_d = ptc_pkg::BK_AREA_MUL;
			ptc_pkg::BK_AREA_MUL: state_d = ptc_pkg::BK_AREA;
			ptc_pkg::BK_AREA:     state_d = ptc_pkg::BK_ABS;
			ptc_pkg::BK_ABS: begin
				// degenerate triangle counts nothing
				state_d = (area_q == '0) ? ptc_pkg::BK_RESULT : ptc_pkg::BK_SCAN;
			end
			ptc_pkg::BK_SCAN: begin
				rd_en      = 1'b1;
				rd_addr    = j_q[ptc_pkg::IDX_W-1:0];
				scan_issue = 1'b1;
				if (j_q == n_eff - 1'b1) begin
					state_d = ptc_pkg::BK_DRAIN;
				end
			end
			ptc_pkg::BK_DRAIN: begin
				if (!(v_s1 || v_s2 || v_s3 || v_s4 || v_s5)) begin
					state_d = ptc_pkg::BK_RESULT;
				end
			end
			ptc_pkg::BK_RESULT: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = ptc_pkg::BK_IDLE;
				end
			end
			default: state_d = ptc_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptc_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// store: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[q_entry.vertex_index] <= {q_entry.coord_x, q_entry.coord_y};
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// corner and area datapath
	always_ff @(posedge clk) begin
		if (state_q == ptc_pkg::BK_IDLE && q_valid) begin
			cur_q <= q_entry;
			bad_q <= q_entry.bad;
		end
		if (state_q == ptc_pkg::BK_RD_B) begin
			pa_x_q <= rd_x;
			pa_y_q <= rd_y;
		end
		if (state_q == ptc_pkg::BK_RD_C) begin
			pb_x_q <= rd_x;
			pb_y_q <= rd_y;
		end
		if (state_q == ptc_pkg::BK_CAP_C) begin
			e1x_q <= DW'(pb_x_q) - DW'(pa_x_q);
			e1y_q <= DW'(pb_y_q) - DW'(pa_y_q);
			e2x_q <= DW'(rd_x) - DW'(pa_x_q);
			e2y_q <= DW'(rd_y) - DW'(pa_y_q);
		end
		if (state_q == ptc_pkg::BK_AREA_MUL) begin
			am1_q <= e1x_q * e2y_q;
			am2_q <= e1y_q * e2x_q;
		end
		if (state_q == ptc_pkg::BK_AREA) begin
			area_q <= AW'(am1_q) - AW'(am2_q);
		end
		if (state_q == ptc_pkg::BK_ABS) begin
			flip_q <= area_q[AW-1];
			if (area_q[AW-1]) begin
				area_q <= -area_q;
			end
		end
	end

	// scan pipeline payload
	always_ff @(posedge clk) begin
		dx_s2       <= DW'(rd_x) - DW'(pa_x_q);
		dy_s2       <= DW'(rd_y) - DW'(pa_y_q);
		p_e2y_dx_s3 <= e2y_q * dx_s2;
		p_e2x_dy_s3 <= e2x_q * dy_s2;
		p_e1x_dy_s3 <= e1x_q * dy_s2;
		p_e1y_dx_s3 <= e1y_q * dx_s2;
		// negative area: swap operands instead of negating
		s_s4 <= flip_q ? (AW'(p_e2x_dy_s3) - AW'(p_e2y_dx_s3))
		               : (AW'(p_e2y_dx_s3) - AW'(p_e2x_dy_s3));
		t_s4 <= flip_q ? (AW'(p_e1y_dx_s3) - AW'(p_e1x_dy_s3))
		               : (AW'(p_e1x_dy_s3) - AW'(p_e1y_dx_s3));
		s_pos_s5 <= !s_s4[AW-1] && (s_s4 != '0);
		t_pos_s5 <= !t_s4[AW-1] && (t_s4 != '0);
		sum_s5   <= s_s4 + t_s4;
	end

	// control: scan index, tags, hit counter, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q         <= '0;
			count_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			v_s1 <= scan_issue && !corner_hit;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (state_q == ptc_pkg::BK_IDLE && q_valid) begin
				count_q <= '0;
			end else if (hit) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == ptc_pkg::BK_ABS) begin
				j_q <= '0;
			end else if (scan_issue) begin
				j_q <= j_q + 1'b1;
			end
			if (state_q == ptc_pkg::BK_RESULT && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ptc_pkg::BK_RESULT && (!rsp_valid_q || rsp_ready)) begin
			rsp_q.inside_count <= count_q;
			rsp_q.bad_index    <= bad_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

>>> design/ptc_checker.sv
// ----------------------------------------------------------------------------
// ptc_checker: port-level assertions for the points-in-triangle counter
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        rsp_valid,
	input  wire logic                        rsp_ready,
	input  wire ptc_pkg::rsp_t               rsp
);

	// response held until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response dropped or changed while stalled");

	// a bad corner never reports a count
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.bad_index |-> rsp.inside_count == '0)
		else $error("bad_index with nonzero count");

	// three corners are never counted
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.inside_count <=
			ptc_pkg::CNT_W'(ptc_pkg::MAX_VERTICES - 3))
		else $error("count exceeds possible vertices");

	// no response while reset is applied
	a_rst_quiet: assert property (@(posedge clk)
		!arst_n |-> !rsp_valid)
		else $error("response valid during reset");

endmodule

bind points_in_triangle_count ptc_checker u_ptc_checker (.*);

`default_nettype wire

>>> dv/points_in_triangle_count_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// points_in_triangle_count_test: self-checking bench for the triangle counter
// Loads vertex tables, sets vertex_count, and checks each query response against
// an in-bench integer predictor or a fixed want, under random idling on both sides.
// ----------------------------------------------------------------------------

module points_in_triangle_count_test;

	localparam int RANDOM_ITEMS  = 500;
	localparam int CYCLE_LIMIT   = 1000000;
	// covers loads still sitting in the two-entry queue once responses are in
	localparam int SETTLE_CYCLES = 16;
	localparam int DIRECTED_ROWS = 21;

	typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {SPREAD_FULL, SPREAD_MID, SPREAD_TIGHT} spread_t;

	// load: f0 = slot, f1 = x, f2 = y; query: f0..f2 = corners; cfg: f0 = count
	typedef struct {
		row_kind_t kind;
		int        f0;
		int        f1;
		int        f2;
		bit        fixed;
		int        want_count;
		bit        want_bad;
	} stim_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      req_valid;
	logic                      req_ready;
	ptc_pkg::req_t             req;
	logic                      rsp_valid;
	logic                      rsp_ready;
	ptc_pkg::rsp_t             rsp;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [ptc_pkg::CNT_W-1:0] cfg_data;

	// predictor state: vertex table, which slots hold data, current vertex_count
	logic signed [ptc_pkg::COORD_BITS-1:0] pt_x [ptc_pkg::MAX_VERTICES];
	logic signed [ptc_pkg::COORD_BITS-1:0] pt_y [ptc_pkg::MAX_VERTICES];
	bit                                    pt_loaded [ptc_pkg::MAX_VERTICES];
	logic [ptc_pkg::CNT_W-1:0]             vcount_setting;

	// responses owed by the DUT, oldest first
	ptc_pkg::rsp_t expected_counts [$];
	ptc_pkg::rsp_t seen_want;

	int      err_count;
	int      cycle_count;
	int      queries_sent;
	int      loads_sent;
	int      results_seen;
	int      settings_used;
	int      gap_max;
	int      stall_max;
	int      rsp_hold;
	spread_t spread;

	points_in_triangle_count u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d responses still owed",
				cycle_count, expected_counts.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Exact barycentric test relative to corner a. Differences are 25 bits and
	// products 50 bits, so 64-bit signed math never overflows. A negative area
	// flips orientation: S and T are negated and the area taken as magnitude.
	function automatic ptc_pkg::rsp_t count_inside(input ptc_pkg::req_t q);
		ptc_pkg::rsp_t r;
		int            n;
		int            hits;
		int            j;
		longint        ax, ay, e1x, e1y, e2x, e2y, area, dx, dy, s, t;
		r = '0;
		n = int'(vcount_setting);
		if (n > ptc_pkg::MAX_VERTICES)
			n = ptc_pkg::MAX_VERTICES;
		if (int'(q.corner_a) >= n || int'(q.corner_b) >= n || int'(q.corner_c) >= n) begin
			r.bad_index = 1'b1;
			return r;
		end
		ax   = pt_x[q.corner_a];
		ay   = pt_y[q.corner_a];
		e1x  = longint'(pt_x[q.corner_b]) - ax;
		e1y  = longint'(pt_y[q.corner_b]) - ay;
		e2x  = longint'(pt_x[q.corner_c]) - ax;
		e2y  = longint'(pt_y[q.corner_c]) - ay;
		area = e1x * e2y - e1y * e2x;
		if (area == 0)
			return r;
		hits = 0;
		for (j = 0; j < n; j++) begin
			if (j == int'(q.corner_a) || j == int'(q.corner_b) || j == int'(q.corner_c))
				continue;
			dx = longint'(pt_x[j]) - ax;
			dy = longint'(pt_y[j]) - ay;
			s  = e2y * dx - e2x * dy;
			t  = e1x * dy - e1y * dx;
			if (area < 0) begin
				s = -s;
				t = -t;
			end
			if (s > 0 && t > 0 && s + t < (area < 0 ? -area : area))
				hits++;
		end
		r.inside_count = ptc_pkg::CNT_W'(hits);
		return r;
	endfunction

	function automatic logic signed [ptc_pkg::COORD_BITS-1:0] draw_coord();
		int roll;
		roll = $urandom_range(0, 15);
		if (roll == 0)
			return {1'b1, {(ptc_pkg::COORD_BITS-1){1'b0}}};
		if (roll == 1)
			return {1'b0, {(ptc_pkg::COORD_BITS-1){1'b1}}};
		case (spread)
		SPREAD_FULL: return ptc_pkg::COORD_BITS'($urandom());
		SPREAD_MID:  return ptc_pkg::COORD_BITS'(int'($urandom_range(0, 8191)) - 4096);
		// tight spread makes collinear corners and points on edges common
		default:     return ptc_pkg::COORD_BITS'(int'($urandom_range(0, 16)) - 8);
		endcase
	endfunction

	// One request transaction. Gap cycles hold valid low; with no gap valid
	// stays high straight into the next transaction. The prediction is made
	// at acceptance, so queue order in the DUT matches predictor order.
	task automatic send_item(input ptc_pkg::req_t item, input bit fixed,
	                         input ptc_pkg::rsp_t want);
		int gap;
		gap = $urandom_range(0, gap_max);
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		if (item.req_type == ptc_pkg::OP_QUERY) begin
			expected_counts.push_back(fixed ? want : count_inside(item));
			queries_sent++;
		end else begin
			pt_x[item.vertex_index]      = item.coord_x;
			pt_y[item.vertex_index]      = item.coord_y;
			pt_loaded[item.vertex_index] = 1'b1;
			loads_sent++;
		end
	endtask

	// Stop sending, let all owed responses arrive, then let queued loads retire.
	task automatic wait_idle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_counts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_vertex_count(input logic [ptc_pkg::CNT_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		vcount_setting = value;
		settings_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Response side: compare each accepted transaction with the oldest
	// expectation, then draw the stall for the next one.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			results_seen++;
			if (expected_counts.size() == 0) begin
				$error("response with no query outstanding: inside_count %0d bad_index %0d",
					rsp.inside_count, rsp.bad_index);
				err_count++;
			end else begin
				seen_want = expected_counts.pop_front();
				if (rsp.inside_count !== seen_want.inside_count) begin
					$error("inside_count: expected %0d, got %0d",
						seen_want.inside_count, rsp.inside_count);
					err_count++;
				end
				if (rsp.bad_index !== seen_want.bad_index) begin
					$error("bad_index: expected %0d, got %0d",
						seen_want.bad_index, rsp.bad_index);
					err_count++;
				end
			end
			rsp_hold <= $urandom_range(0, stall_max);
		end
	end

	// The stall only counts down while a response is presented, so it always
	// lands on the response itself; ready also drops ahead of valid.
	always @(negedge clk) begin
		if (rsp_hold != 0) begin
			rsp_ready <= 1'b0;
			if (rsp_valid)
				rsp_hold <= rsp_hold - 1;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	initial begin
		stim_row_t                 directed_rows [DIRECTED_ROWS];
		stim_row_t                 row;
		ptc_pkg::req_t             item;
		ptc_pkg::rsp_t             want;
		logic [ptc_pkg::CNT_W-1:0] setting;
		int                        n_eff;
		int                        plen;
		int                        roll;
		int                        phase;
		int                        slot;
		int                        random_done;

		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req            = '0;
		rsp_ready      = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		vcount_setting = '0;
		err_count      = 0;
		cycle_count    = 0;
		queries_sent   = 0;
		loads_sent     = 0;
		results_seen   = 0;
		settings_used  = 0;
		gap_max        = 5;
		stall_max      = 5;
		rsp_hold       = 0;
		spread         = SPREAD_FULL;
		foreach (pt_x[i]) begin
			pt_x[i]      = '0;
			pt_y[i]      = '0;
			pt_loaded[i] = 1'b0;
		end

		// Corners 0..2 span the full coordinate range. Slot 3 and 7 sit inside,
		// slot 4 on edge a-b, slot 5 outside and collinear with a and 3, slot 6
		// on top of corner a. Slot 1023 sets every index and coordinate bit.
		directed_rows = '{
			'{ROW_QUERY,       0,        0,        0, 1'b1, 0, 1'b1}, // nothing enabled
			'{ROW_LOAD,        0, -8388608, -8388608, 1'b0, 0, 1'b0},
			'{ROW_LOAD,        1,  8388607, -8388608, 1'b0, 0, 1'b0},
			'{ROW_LOAD,        2,        0,  8388607, 1'b0, 0, 1'b0},
			'{ROW_LOAD,        3,        0,        0, 1'b0, 0, 1'b0},
			'{ROW_LOAD,        4,        0, -8388608, 1'b0, 0, 1'b0},
			'{ROW_LOAD,        5,  8388607,  8388607, 1'b0, 0, 1'b0},
			'{ROW_LOAD,        6, -8388608, -8388608, 1'b0, 0, 1'b0},
			'{ROW_LOAD,        7,        1,       -1, 1'b0, 0, 1'b0},
			'{ROW_LOAD,     1023,       -1,       -1, 1'b0, 0, 1'b0},
			'{ROW_CFG,         8,        0,        0, 1'b0, 0, 1'b0},
			'{ROW_QUERY,       0,        1,        2, 1'b0, 0, 1'b0}, // ccw
			'{ROW_QUERY,       2,        1,        0, 1'b0, 0, 1'b0}, // cw, negative area
			'{ROW_QUERY,       1,        1,        2, 1'b1, 0, 1'b0}, // repeated corner
			'{ROW_QUERY,       0,        3,        5, 1'b1, 0, 1'b0}, // collinear corners
			'{ROW_QUERY,       0,        6,        1, 1'b1, 0, 1'b0}, // coincident corners
			'{ROW_QUERY,       0,        1,        8, 1'b1, 0, 1'b1}, // corner at the limit
			'{ROW_QUERY,    1023,     1023,     1023, 1'b1, 0, 1'b1}, // top index
			'{ROW_QUERY,       3,        7,        5, 1'b0, 0, 1'b0},
			'{ROW_CFG,         0,        0,        0, 1'b0, 0, 1'b0},
			'{ROW_QUERY,       0,        1,        2, 1'b1, 0, 1'b1}  // count back to zero
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part
		foreach (directed_rows[i]) begin
			row  = directed_rows[i];
			item = '0;
			want = '0;
			case (row.kind)
			ROW_CFG: begin
				wait_idle();
				write_vertex_count(ptc_pkg::CNT_W'(row.f0));
			end
			ROW_LOAD: begin
				item.req_type     = ptc_pkg::OP_LOAD;
				item.vertex_index = ptc_pkg::IDX_W'(row.f0);
				item.coord_x      = ptc_pkg::COORD_BITS'(row.f1);
				item.coord_y      = ptc_pkg::COORD_BITS'(row.f2);
				send_item(item, 1'b0, want);
			end
			default: begin
				item.req_type     = ptc_pkg::OP_QUERY;
				item.corner_a     = ptc_pkg::IDX_W'(row.f0);
				item.corner_b     = ptc_pkg::IDX_W'(row.f1);
				item.corner_c     = ptc_pkg::IDX_W'(row.f2);
				want.inside_count = ptc_pkg::CNT_W'(row.want_count);
				want.bad_index    = row.want_bad;
				send_item(item, row.fixed, want);
			end
			endcase
		end

		// random part: phases, each with its own vertex_count, idling and spread
		random_done = 0;
		phase       = 0;
		while (random_done < RANDOM_ITEMS) begin
			case (phase)
			9: setting = '0;
			default: begin
				roll = $urandom_range(0, 9);
				if (roll == 0)
					setting = ptc_pkg::CNT_W'($urandom_range(0, 2));
				else if (roll < 6)
					setting = ptc_pkg::CNT_W'($urandom_range(3, 12));
				else if (roll < 9)
					setting = ptc_pkg::CNT_W'($urandom_range(13, 48));
				else
					setting = ptc_pkg::CNT_W'($urandom_range(49, 64));
			end
			endcase
			n_eff = (int'(setting) > ptc_pkg::MAX_VERTICES) ?
			        ptc_pkg::MAX_VERTICES : int'(setting);
			plen      = int'($urandom_range(15, 45));
			gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 5;
			stall_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
			spread    = spread_t'($urandom_range(0, 2));

			// every slot a query may scan must hold data before it is enabled
			for (slot = 0; slot < n_eff; slot++) begin
				if (!pt_loaded[slot]) begin
					item              = '0;
					item.req_type     = ptc_pkg::OP_LOAD;
					item.vertex_index = ptc_pkg::IDX_W'(slot);
					item.coord_x      = draw_coord();
					item.coord_y      = draw_coord();
					send_item(item, 1'b0, '0);
				end
			end
			wait_idle();
			write_vertex_count(setting);

			repeat (plen) begin
				// now and then hold off until every owed response is back
				if ($urandom_range(0, 49) == 0)
					wait_idle();
				item.req_type     = $urandom_range(0, 1) ? ptc_pkg::OP_QUERY : ptc_pkg::OP_LOAD;
				item.vertex_index = ptc_pkg::IDX_W'($urandom());
				item.coord_x      = draw_coord();
				item.coord_y      = draw_coord();
				item.corner_a     = ptc_pkg::IDX_W'($urandom());
				item.corner_b     = ptc_pkg::IDX_W'($urandom());
				item.corner_c     = ptc_pkg::IDX_W'($urandom());
				if (item.req_type == ptc_pkg::OP_QUERY) begin
					// mostly enabled corners; the rest stays random as bad-index noise
					roll = $urandom_range(0, 9);
					if (n_eff > 0 && roll > 0) begin
						item.corner_a = ptc_pkg::IDX_W'($urandom_range(0, n_eff - 1));
						item.corner_b = ptc_pkg::IDX_W'($urandom_range(0, n_eff - 1));
						item.corner_c = ptc_pkg::IDX_W'($urandom_range(0, n_eff - 1));
						if (roll == 1)
							item.corner_b = item.corner_a;
					end
				end else if (n_eff > 0 && $urandom_range(0, 99) < 85) begin
					item.vertex_index = ptc_pkg::IDX_W'($urandom_range(0, n_eff - 1));
				end
				send_item(item, 1'b0, '0);
				random_done++;
			end
			phase++;
		end

		wait_idle();
		$display("Run: %0d queries and %0d loads over %0d vertex_count settings",
			queries_sent, loads_sent, settings_used);
		$display("Responses checked: %0d, mismatches: %0d, cycles: %0d",
			results_seen, err_count, cycle_count);
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
design/ptc_pkg.sv
design/ptc_front.sv
design/ptc_back.sv
design/points_in_triangle_count.sv
design/ptc_checker.sv
dv/points_in_triangle_count_test.sv
